>>> sv/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the stream substring replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPL_MAX        = 8;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [2:0] CSR_PATTERN_BYTES = 3'd0;
   localparam logic [2:0] CSR_PATTERN_LEN   = 3'd1;
   localparam logic [2:0] CSR_REPL_BYTES    = 3'd2;
   localparam logic [2:0] CSR_REPL_LEN      = 3'd3;
   localparam logic [2:0] CSR_REPLACE_LIMIT = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPL,
      ST_FLUSH
   } state_type;

   // what one cell sees of its right neighbor
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } slot_type;

endpackage

`default_nettype wire

>>> sv/ssr_cell.sv
// ----------------------------------------------------------------------------
// ssr_cell
// One slot of the held-byte row: loads, shifts left, and compares its byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_cell
   import ssr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic       shift,
   input  wire logic       clear,
   input  wire slot_type   load_slot,
   input  wire slot_type   right_slot,
   input  wire logic [7:0] pat_byte,
   output slot_type        slot,
   output logic            hit
);

   slot_type slot_ff, slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (clear) begin
         slot_in.valid = 1'b0;
      end else if (load) begin
         slot_in = load_slot;
      end else if (shift) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.data <= slot_in.data;
   end

   assign slot = slot_ff;
   assign hit  = !slot_ff.valid || (slot_ff.data == pat_byte);

endmodule

`default_nettype wire

>>> sv/stream_substring_replacer_unit.sv
// ----------------------------------------------------------------------------
// stream_substring_replacer_unit
// Streaming find-and-replace over a byte stream with a row of compare cells.
// ----------------------------------------------------------------------------
// Usage: source bytes enter on req_ (req_in_byte, req_in_last) with a
// valid/stall handshake; rewritten bytes leave on rsp_ (rsp_out_byte,
// rsp_byte_valid, rsp_out_last). csr_ writes set pattern, replacement and
// limit; the user must make them only while the block is idle, since the
// block itself does not enforce this. One source beat is accepted when the
// block is idle. The work list (held bytes plus the new byte) sits in a row
// of PATTERN_MAX cells that shift left one cell per cycle while the output
// is not stalled; every cycle at most one result beat is produced (a
// released byte, a replacement byte or a flushed byte). An item is loaded,
// then each result beat is sent, then the match or that nothing is left to
// release is seen; a string end adds the final beat.
// At a string end the newest beat is kept back in a tail register so it
// can carry the last flag; with no beat at all a marker-only beat is sent.
// The result register is a single stage: when the receiver stalls, the row
// stops shifting and no new beat is produced until the waiting one is taken.
// Reset clears cells, counters and configuration (pattern length becomes 1).
// ----------------------------------------------------------------------------
`default_nettype none

module stream_substring_replacer_unit
   import ssr_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_out_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int CW = $clog2(PATTERN_MAX + 1);

   // configuration
   logic [63:0] pat_ff, repl_ff;
   logic [3:0]  plen_raw_ff, rlen_raw_ff;
   logic [15:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff      <= '0;
         plen_raw_ff <= 4'd1;
         repl_ff     <= '0;
         rlen_raw_ff <= '0;
         limit_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_BYTES: pat_ff      <= csr_data;
            CSR_PATTERN_LEN:   plen_raw_ff <= csr_data[3:0];
            CSR_REPL_BYTES:    repl_ff     <= csr_data;
            CSR_REPL_LEN:      rlen_raw_ff <= csr_data[3:0];
            CSR_REPLACE_LIMIT: limit_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] plen;
   logic [3:0]    rlen;
   always_comb begin
      if (plen_raw_ff == 4'd0) begin
         plen = CW'(1);
      end else if (32'(plen_raw_ff) > PATTERN_MAX) begin
         plen = CW'(PATTERN_MAX);
      end else begin
         plen = CW'(plen_raw_ff);
      end
      rlen = (rlen_raw_ff > 4'(REPL_MAX)) ? 4'(REPL_MAX) : rlen_raw_ff;
   end

   // control state
   state_type     state_ff, state_in;
   logic [CW-1:0] len_ff, len_in;       // valid cells, packed from cell 0
   logic [3:0]    ridx_ff, ridx_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic          pass_ff, pass_in;     // limit reached at load time

   logic          o_valid_ff, o_valid_in;
   logic [7:0]    o_byte_ff, o_byte_in;
   logic          o_bv_ff, o_bv_in;
   logic          o_last_ff, o_last_in;

   // newest beat of a string end, kept back so it can carry last
   logic          tail_valid_ff, tail_valid_in;
   logic [7:0]    tail_byte_ff, tail_byte_in;

   logic          emit_beat;
   logic [7:0]    emit_byte;

   // cell row
   slot_type             slots [PATTERN_MAX];
   slot_type             loads [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hits;
   logic                 do_load, do_shift, do_clear;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_row
      slot_type right;
      if (g == PATTERN_MAX - 1) begin : g_end
         assign right = '0;
      end else begin : g_mid
         assign right = slots[g+1];
      end
      ssr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (do_load),
         .shift      (do_shift),
         .clear      (do_clear),
         .load_slot  (loads[g]),
         .right_slot (right),
         .pat_byte   (pat_ff[8*g +: 8]),
         .slot       (slots[g]),
         .hit        (hits[g])
      );
   end

   // new byte goes into the first free cell
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         loads[k] = slots[k];
         if (CW'(k) == len_ff) begin
            loads[k].valid = 1'b1;
            loads[k].data  = req_in_byte;
         end
      end
   end

   logic is_prefix, full_match, limit_hit, out_free;
   assign is_prefix  = &hits && (len_ff <= plen);
   assign full_match = is_prefix && (len_ff == plen);
   assign limit_hit  = (limit_ff != 16'd0) && (cnt_ff >= limit_ff);
   assign out_free   = !o_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (out_free) begin
               if (len_ff == '0) begin
                  state_in = last_ff ? ST_FLUSH : ST_IDLE;
               end else if (!pass_ff && full_match) begin
                  state_in = (rlen != 4'd0) ? ST_REPL : (last_ff ? ST_FLUSH : ST_IDLE);
               end else if (!pass_ff && is_prefix) begin
                  state_in = last_ff ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_REPL: begin
            if (out_free && ridx_ff == rlen - 4'd1) begin
               state_in = last_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free && len_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      do_load       = 1'b0;
      do_shift      = 1'b0;
      do_clear      = 1'b0;
      emit_beat     = 1'b0;
      emit_byte     = slots[0].data;
      len_in        = len_ff;
      ridx_in       = ridx_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      pass_in       = pass_ff;
      tail_valid_in = tail_valid_ff;
      tail_byte_in  = tail_byte_ff;
      o_valid_in    = o_valid_ff && rsp_stall;
      o_byte_in     = o_byte_ff;
      o_bv_in       = o_bv_ff;
      o_last_in     = o_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               do_load = 1'b1;
               len_in  = len_ff + CW'(1);
               last_in = req_in_last;
               pass_in = limit_hit;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (len_ff == '0) begin
                  // nothing left
               end else if (!pass_ff && full_match) begin
                  do_clear = 1'b1;
                  len_in   = '0;
                  ridx_in  = '0;
                  if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 16'd1;
               end else if (!pass_ff && is_prefix) begin
                  // keep held bytes
               end else begin
                  // release oldest byte
                  do_shift  = 1'b1;
                  len_in    = len_ff - CW'(1);
                  emit_beat = 1'b1;
                  emit_byte = slots[0].data;
               end
            end
         end
         ST_REPL: begin
            if (out_free) begin
               emit_beat = 1'b1;
               emit_byte = repl_ff[8*ridx_ff[2:0] +: 8];
               ridx_in   = ridx_ff + 4'd1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               if (len_ff == '0) begin
                  // final beat of the string, marker only if nothing is kept
                  o_valid_in    = 1'b1;
                  o_byte_in     = tail_valid_ff ? tail_byte_ff : '0;
                  o_bv_in       = tail_valid_ff;
                  o_last_in     = 1'b1;
                  tail_valid_in = 1'b0;
                  cnt_in        = '0;
               end else begin
                  do_shift  = 1'b1;
                  len_in    = len_ff - CW'(1);
                  emit_beat = 1'b1;
                  emit_byte = slots[0].data;
               end
            end
         end
         default: ;
      endcase

      if (emit_beat) begin
         if (last_ff) begin
            tail_valid_in = 1'b1;
            tail_byte_in  = emit_byte;
            if (tail_valid_ff) begin
               o_valid_in = 1'b1;
               o_byte_in  = tail_byte_ff;
               o_bv_in    = 1'b1;
               o_last_in  = 1'b0;
            end
         end else begin
            o_valid_in = 1'b1;
            o_byte_in  = emit_byte;
            o_bv_in    = 1'b1;
            o_last_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         cnt_ff        <= '0;
         o_valid_ff    <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         cnt_ff        <= cnt_in;
         o_valid_ff    <= o_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      ridx_ff      <= ridx_in;
      last_ff      <= last_in;
      pass_ff      <= pass_in;
      tail_byte_ff <= tail_byte_in;
      o_byte_ff    <= o_byte_in;
      o_bv_ff      <= o_bv_in;
      o_last_ff    <= o_last_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = o_valid_ff;
   assign rsp_out_byte   = o_byte_ff;
   assign rsp_byte_valid = o_bv_ff;
   assign rsp_out_last   = o_last_ff;

endmodule

`default_nettype wire
